>>> hw/rtl/lbs_pkg.sv
`default_nettype none
package lbs_pkg;

  localparam int MAX_BONES  = 256;
  localparam int BONE_W     = 8;
  localparam int BC_W       = 9;
  localparam int ROWS       = 4;
  localparam int COLS       = 3;
  localparam int INFL       = 4;
  localparam int VAL_W      = 32;
  localparam int ROW_W      = COLS * VAL_W;
  localparam int W_W        = 16;
  localparam int WSUM_W     = 18;
  localparam int T_W        = 44;
  localparam int ACC_W      = 62;
  localparam int Q_W        = 32;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = Q_W / DIV_STEP;

  // status codes
  localparam logic [1:0] ST_SKIN = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  typedef struct packed {
    logic [ACC_W-1:0]  num;
    logic [WSUM_W-1:0] den;
  } div_in_t;

endpackage
`default_nettype wire

>>> hw/rtl/lbs_ram.sv
`default_nettype none
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> hw/rtl/lbs_div.sv
`default_nettype none
module lbs_div (
  input  logic                     clk,
  input  logic                     en,
  input  lbs_pkg::div_in_t         din,
  output logic [lbs_pkg::Q_W-1:0]  quo
);
  import lbs_pkg::*;

  logic [WSUM_W-1:0] rem_r  [DIV_STAGES];
  logic [Q_W-1:0]    word_r [DIV_STAGES];
  logic [WSUM_W-1:0] den_r  [DIV_STAGES];

  // restoring division, a few quotient bits per stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [WSUM_W-1:0] rem_in;
    logic [Q_W-1:0]    word_in;
    logic [WSUM_W-1:0] den_in;
    logic [WSUM_W-1:0] rem_nxt;
    logic [Q_W-1:0]    word_nxt;
    logic [WSUM_W:0]   trial;

    if (s == 0) begin : g_first
      // upper numerator bits are below the divisor when no saturation
      assign rem_in  = din.num[Q_W +: WSUM_W];
      assign word_in = din.num[Q_W-1:0];
      assign den_in  = din.den;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign word_in = word_r[s-1];
      assign den_in  = den_r[s-1];
    end

    always_comb begin
      rem_nxt  = rem_in;
      word_nxt = word_in;
      trial    = '0;
      for (int k = 0; k < DIV_STEP; k++) begin
        trial    = {rem_nxt, word_nxt[Q_W-1]};
        word_nxt = {word_nxt[Q_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_nxt     = WSUM_W'(trial - {1'b0, den_in});
          word_nxt[0] = 1'b1;
        end else begin
          rem_nxt = trial[WSUM_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        word_r[s] <= word_nxt;
        den_r[s]  <= den_in;
      end
    end
  end

  assign quo = word_r[DIV_STAGES-1];

endmodule
`default_nettype wire

>>> hw/rtl/linear_blend_vertex_skinning_unit.sv
// A vertex issues four skin matrix reads (one per influence) from the row-banked
// matrix memory, and the next vertex is taken only with the last read of the previous
// one; row loads are taken one per cycle while the output is not stalled.
// Reset: synchronous, active low; clears the pipeline valids and the sequencer and sets
// bone_count to 1. The matrix memory is not cleared and holds garbage until loaded.
`default_nettype none
module linear_blend_vertex_skinning_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [31:0]        in_bone_ids,
  input  logic [15:0]        in_weight_a,
  input  logic [15:0]        in_weight_b,
  input  logic [15:0]        in_weight_c,
  input  logic [15:0]        in_weight_d,
  input  logic [7:0]         in_load_bone,
  input  logic [1:0]         in_load_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [1:0]         out_status
);
  import lbs_pkg::*;

  typedef struct packed {
    logic [1:0]        code;
    logic [WSUM_W-1:0] wsum;
    logic [ROW_W-1:0]  pos;
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic [COLS-1:0] neg;
    logic [COLS-1:0] sat;
  } fin_t;

  logic             adv;
  logic             in_xfer;
  logic             issue;
  logic             sl_last;
  logic [BONE_W-1:0] sl_id;
  logic [W_W-1:0]   sl_w;
  logic [WSUM_W-1:0] wsum;
  logic             bad;
  logic [1:0]       code;

  logic [BC_W-1:0]  bone_count_r;
  logic             pend_r;
  logic [1:0]       cnt_r;
  logic             it_func_r;
  logic [ROW_W-1:0] it_pos_r;
  logic [31:0]      it_ids_r;
  logic [W_W-1:0]   it_w_r [INFL];
  logic [BONE_W-1:0] it_bone_r;
  logic [1:0]       it_row_r;

  logic [ROW_W-1:0] m_row [ROWS];

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic s1_first_r, s2_first_r, s3_first_r, s4_first_r;
  logic s1_last_r, s2_last_r, s3_last_r, s4_last_r;
  logic [W_W-1:0] s1_w_r, s2_w_r, s3_w_r;
  tag_t s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r, s5_tag_r, s6_tag_r, s7_tag_r, s8_tag_r;

  logic signed [63:0]      s2_p_r  [COLS][3];
  logic signed [VAL_W-1:0] s2_m3_r [COLS];
  logic signed [T_W-1:0]   t_nxt   [COLS];
  logic signed [T_W-1:0]   s3_t_r  [COLS];
  logic signed [ACC_W-1:0] wt_nxt  [COLS];
  logic signed [ACC_W-1:0] s4_wt_r [COLS];
  logic signed [ACC_W-1:0] acc_r   [COLS];
  logic [ACC_W-1:0]        s6_mag_r [COLS];
  logic [ACC_W-1:0]        s7_n_r   [COLS];
  logic [ACC_W-1:0]        s8_n_r   [COLS];
  logic [COLS-1:0]         s6_neg_r, s7_neg_r, s8_neg_r, s8_sat_r;
  logic [Q_W-1:0]          div_q   [COLS];

  logic            d_v_r [DIV_STAGES];
  fin_t            d_fin_r [DIV_STAGES];
  logic [VAL_W-1:0] res [COLS];

  logic             out_valid_r;
  logic [VAL_W-1:0] out_val_r [COLS];
  logic [1:0]       out_status_r;

  // the whole pipeline moves when the output register can take a transfer
  assign adv     = !out_valid_r || !out_stall;
  assign sl_last = !it_func_r || (cnt_r == 2'(INFL - 1));
  assign in_stall = !adv || (pend_r && !sl_last);
  assign in_xfer  = in_valid && !in_stall;
  assign issue    = adv && pend_r;
  assign sl_id    = it_ids_r[{cnt_r, 3'b000} +: BONE_W];
  assign sl_w     = it_w_r[cnt_r];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bone_count_r <= BC_W'(1);
    end else if (cfg_we) begin
      bone_count_r <= cfg_wdata;
    end
  end

  // weight total and bad bone check of the held item
  always_comb begin
    wsum = '0;
    bad  = 1'b0;
    for (int i = 0; i < INFL; i++) begin
      if (it_w_r[i] != '0) begin
        wsum = wsum + WSUM_W'(it_w_r[i]);
        if ({1'b0, it_ids_r[i*BONE_W +: BONE_W]} >= bone_count_r) begin
          bad = 1'b1;
        end
      end
    end
    priority if (!it_func_r) begin
      code = ST_LOAD;
    end else if (bad) begin
      code = ST_BAD;
    end else if (wsum == '0) begin
      code = ST_ZERO;
    end else begin
      code = ST_SKIN;
    end
  end

  // sequencer: one slot per influence, one slot per row load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      cnt_r  <= '0;
    end else if (in_xfer) begin
      pend_r <= 1'b1;
      cnt_r  <= '0;
    end else if (issue) begin
      if (sl_last) begin
        pend_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  // held item
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      it_func_r <= in_func;
      it_pos_r  <= {in_pos_z, in_pos_y, in_pos_x};
      it_ids_r  <= in_bone_ids;
      it_w_r[0] <= in_weight_a;
      it_w_r[1] <= in_weight_b;
      it_w_r[2] <= in_weight_c;
      it_w_r[3] <= in_weight_d;
      it_bone_r <= in_load_bone;
      it_row_r  <= in_load_row;
    end
  end

  // matrix memory, one bank per row, all twelve entries read in the same cycle
  for (genvar r = 0; r < ROWS; r++) begin : g_bank
    lbs_ram #(
      .WIDTH(ROW_W),
      .DEPTH(MAX_BONES)
    ) u_ram (
      .clk  (clk),
      .we   (issue && !it_func_r && (it_row_r == 2'(r))),
      .waddr(it_bone_r),
      .wdata(it_pos_r),
      .re   (adv),
      .raddr(sl_id),
      .rdata(m_row[r])
    );
  end

  // translation result per column, saturated to the transform width
  always_comb begin
    logic signed [65:0] sum66;
    logic signed [65:0] tf;
    for (int c = 0; c < COLS; c++) begin
      sum66 = 66'(s2_p_r[c][0]) + 66'(s2_p_r[c][1]) + 66'(s2_p_r[c][2]);
      tf    = (sum66 >>> 16) + 66'(s2_m3_r[c]);
      if ((&tf[65:T_W-1]) || !(|tf[65:T_W-1])) begin
        t_nxt[c] = tf[T_W-1:0];
      end else if (tf[65]) begin
        t_nxt[c] = {1'b1, {(T_W-1){1'b0}}};
      end else begin
        t_nxt[c] = {1'b0, {(T_W-1){1'b1}}};
      end
    end
  end

  // weight times transform
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      wt_nxt[c] = $signed({1'b0, s3_w_r}) * s3_t_r[c];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
      for (int d = 0; d < DIV_STAGES; d++) begin
        d_v_r[d] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r && s4_last_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
      d_v_r[0] <= s8_v_r;
      for (int d = 1; d < DIV_STAGES; d++) begin
        d_v_r[d] <= d_v_r[d-1];
      end
      out_valid_r <= d_v_r[DIV_STAGES-1];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // slot issue and memory read
      s1_first_r <= (cnt_r == 2'd0);
      s1_last_r  <= sl_last;
      s1_w_r     <= sl_w;
      s1_tag_r   <= '{code: code, wsum: wsum, pos: it_pos_r};
      // position times matrix, unused influences forced to zero
      for (int c = 0; c < COLS; c++) begin
        for (int r = 0; r < 3; r++) begin
          s2_p_r[c][r] <= $signed(s1_tag_r.pos[r*VAL_W +: VAL_W]) *
                          ((s1_w_r != '0) ? $signed(m_row[r][c*VAL_W +: VAL_W]) : 32'sd0);
        end
        s2_m3_r[c] <= (s1_w_r != '0) ? $signed(m_row[ROWS-1][c*VAL_W +: VAL_W]) : 32'sd0;
      end
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_w_r     <= s1_w_r;
      s2_tag_r   <= s1_tag_r;
      // transform sum
      s3_t_r     <= t_nxt;
      s3_first_r <= s2_first_r;
      s3_last_r  <= s2_last_r;
      s3_w_r     <= s2_w_r;
      s3_tag_r   <= s2_tag_r;
      // weighted transform
      s4_wt_r    <= wt_nxt;
      s4_first_r <= s3_first_r;
      s4_last_r  <= s3_last_r;
      s4_tag_r   <= s3_tag_r;
      // accumulate over the influences of one vertex
      if (s4_v_r) begin
        for (int c = 0; c < COLS; c++) begin
          acc_r[c] <= s4_first_r ? s4_wt_r[c] : acc_r[c] + s4_wt_r[c];
        end
      end
      s5_tag_r <= s4_tag_r;
      // sign and magnitude
      for (int c = 0; c < COLS; c++) begin
        s6_neg_r[c] <= acc_r[c][ACC_W-1];
        s6_mag_r[c] <= acc_r[c][ACC_W-1] ? ACC_W'(-acc_r[c]) : ACC_W'(acc_r[c]);
      end
      s6_tag_r <= s5_tag_r;
      // rounding offset of half the divisor
      for (int c = 0; c < COLS; c++) begin
        s7_n_r[c] <= s6_mag_r[c] + ACC_W'(s6_tag_r.wsum >> 1);
      end
      s7_neg_r <= s6_neg_r;
      s7_tag_r <= s6_tag_r;
      // quotient of 2^32 or more saturates
      for (int c = 0; c < COLS; c++) begin
        s8_sat_r[c] <= s7_n_r[c] >= ACC_W'({s7_tag_r.wsum, 32'b0});
        s8_n_r[c]   <= s7_n_r[c];
      end
      s8_neg_r <= s7_neg_r;
      s8_tag_r <= s7_tag_r;
      // side data alongside the divider
      d_fin_r[0] <= '{tag: s8_tag_r, neg: s8_neg_r, sat: s8_sat_r};
      for (int d = 1; d < DIV_STAGES; d++) begin
        d_fin_r[d] <= d_fin_r[d-1];
      end
    end
  end

  // one divider per column
  for (genvar c = 0; c < COLS; c++) begin : g_div
    lbs_div u_div (
      .clk(clk),
      .en (adv),
      .din('{num: s8_n_r[c], den: s8_tag_r.wsum}),
      .quo(div_q[c])
    );
  end

  // sign, saturation and result select
  always_comb begin
    fin_t f;
    f = d_fin_r[DIV_STAGES-1];
    for (int c = 0; c < COLS; c++) begin
      unique case (f.tag.code)
        ST_SKIN: begin
          if (f.neg[c]) begin
            res[c] = (f.sat[c] || div_q[c] > 32'h8000_0000) ? 32'h8000_0000 : -div_q[c];
          end else begin
            res[c] = (f.sat[c] || div_q[c][Q_W-1]) ? 32'h7fff_ffff : div_q[c];
          end
        end
        ST_ZERO, ST_BAD: res[c] = f.tag.pos[c*VAL_W +: VAL_W];
        ST_LOAD:         res[c] = '0;
        default:         res[c] = '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_val_r    <= res;
      out_status_r <= d_fin_r[DIV_STAGES-1].tag.code;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_val_r[0];
  assign out_y      = out_val_r[1];
  assign out_z      = out_val_r[2];
  assign out_status = out_status_r;

  // a row load is a single slot, a vertex never is
  a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_tag_r.code == ST_LOAD |-> s1_first_r && s1_last_r)
    else $error("row load did not issue as one slot");

  a_vertex_multi: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_first_r && s1_last_r |-> s1_tag_r.code == ST_LOAD)
    else $error("vertex issued as a single slot");

  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_LOAD |-> out_x == 0 && out_y == 0 && out_z == 0)
    else $error("row load answer not zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !pend_r)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
